// ----- rtl/core/mafs_pkg.sv -----
// Shared types, constants and header decode tables for the MPEG audio frame scanner.
// No dependencies; every other file of the block but mafs_div refers to it by scoped names.
`default_nettype none
package mafs_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  SYNC_MASK = 8'hE0;
    localparam logic [7:0]  CHR_I     = 8'h49;
    localparam logic [7:0]  CHR_D     = 8'h44;
    localparam logic [7:0]  CHR_3     = 8'h33;

    localparam logic [17:0] K_LAYER1  = 18'd12000;
    localparam logic [17:0] K_HALF    = 18'd72000;
    localparam logic [17:0] K_FULL    = 18'd144000;

    localparam logic [10:0] SPF_L1    = 11'd384;
    localparam logic [10:0] SPF_HALF  = 11'd576;
    localparam logic [10:0] SPF_FULL  = 11'd1152;
    localparam logic [15:0] HZ_MPEG1_MIN = 16'd32000;

    localparam logic [1:0]  VER_MPEG25 = 2'd0;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  VER_MPEG2  = 2'd2;
    localparam logic [1:0]  VER_MPEG1  = 2'd3;

    localparam logic [1:0]  LAYER_1    = 2'd0;
    localparam logic [1:0]  LAYER_3    = 2'd2;
    localparam logic [1:0]  LAYER_NONE = 2'd3;

    localparam logic [10:0] LEN_MAX    = 11'd2047;
    localparam logic [23:0] SAT24      = 24'hFFFFFF;

    localparam logic [1:0]  DIV_HDR = 2'd0;
    localparam logic [1:0]  DIV_AVG = 2'd1;
    localparam logic [1:0]  DIV_DUR = 2'd2;

    typedef struct packed {
        logic       shift_in;
        logic       shift_drain;
        logic       skip_dec;
        logic       id3_load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       frame_commit;
        logic       out_frame;
        logic       avg_store;
        logic       mul_store;
        logic       out_sum;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic scan_en;
        logic drain_last;
        logic skip_nz;
        logic hdr_ok;
        logic id3_hit;
        logic div_busy;
        logic out_free;
        logic count_nz;
    } t_sts;

    // kbit/s by table row (version*3 + layer) and bitrate index
    function automatic logic [8:0] kbps(input logic [3:0] row, input logic [3:0] idx);
        logic [8:0] r;
        r = 9'd0;
        unique case (row)
            4'd0: begin
                unique case (idx)
                    4'd1: r = 9'd32;   4'd2: r = 9'd64;   4'd3: r = 9'd96;
                    4'd4: r = 9'd128;  4'd5: r = 9'd160;  4'd6: r = 9'd192;
                    4'd7: r = 9'd224;  4'd8: r = 9'd256;  4'd9: r = 9'd288;
                    4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
                    4'd13: r = 9'd416; 4'd14: r = 9'd448;
                    default: r = 9'd0;
                endcase
            end
            4'd1: begin
                unique case (idx)
                    4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
                    4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
                    4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd160;
                    4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
                    4'd13: r = 9'd320; 4'd14: r = 9'd384;
                    default: r = 9'd0;
                endcase
            end
            4'd2: begin
                unique case (idx)
                    4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
                    4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
                    4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
                    4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
                    4'd13: r = 9'd256; 4'd14: r = 9'd320;
                    default: r = 9'd0;
                endcase
            end
            4'd3, 4'd6: begin
                unique case (idx)
                    4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
                    4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
                    4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd144;
                    4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
                    4'd13: r = 9'd224; 4'd14: r = 9'd256;
                    default: r = 9'd0;
                endcase
            end
            4'd4, 4'd5, 4'd7, 4'd8: begin
                unique case (idx)
                    4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
                    4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
                    4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
                    4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
                    4'd13: r = 9'd144; 4'd14: r = 9'd160;
                    default: r = 9'd0;
                endcase
            end
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // sample rate in Hz by version row (0 MPEG-1, 1 MPEG-2, 2 MPEG-2.5) and index
    function automatic logic [15:0] hz(input logic [1:0] vi, input logic [1:0] idx);
        logic [15:0] r;
        r = 16'd0;
        unique case ({vi, idx})
            4'b0000: r = 16'd44100;
            4'b0001: r = 16'd48000;
            4'b0010: r = 16'd32000;
            4'b0100: r = 16'd22050;
            4'b0101: r = 16'd24000;
            4'b0110: r = 16'd16000;
            4'b1000: r = 16'd11025;
            4'b1001: r = 16'd12000;
            4'b1010: r = 16'd8000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mafs_div.sv -----
// Restoring divider, one quotient bit per cycle, registered quotient.
// Uses no package; instantiated by mafs_dp.
`default_nettype none
module mafs_div #(
    parameter int DW = 35,
    parameter int VW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic [VW:0]   trial;
    logic          ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_rem = ge ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
        n_quo = {r_quo[DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_cnt != '0;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- rtl/core/mafs_dp.sv -----
// Datapath: lookahead window, header decode, skip and lock state, counters,
// shared divider and result register. Depends on mafs_pkg and mafs_div.
`default_nettype none
module mafs_dp #(
    parameter int WINDOW_BYTES = 10,
    parameter int COUNT_BITS   = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mafs_pkg::t_cmd   i_cmd,
    output mafs_pkg::t_sts        o_sts,
    input  wire logic [7:0]       i_data_byte,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_result_kind,
    output logic [31:0]           o_frame_offset,
    output logic [10:0]           o_frame_length,
    output logic [8:0]            o_frame_bitrate,
    output logic [23:0]           o_total_frames,
    output logic [8:0]            o_average_bitrate,
    output logic [23:0]           o_duration_seconds,
    output logic [15:0]           o_sample_rate,
    output logic [1:0]            o_layer_code,
    output logic                  o_is_last
);
    localparam int W   = WINDOW_BYTES;
    localparam int CB  = COUNT_BITS;
    localparam int FW  = $clog2(W + 1);
    localparam int SW  = $clog2(W);
    localparam int DW  = CB + 11;
    localparam int VW  = CB;
    localparam int SMW = CB + 9;
    localparam logic [31:0] POS_INIT = ~32'(W) + 32'd1;
    localparam logic [CB-1:0] CNT_MAX = '1;

    logic [7:0]     r_win [W];
    logic [FW-1:0]  r_fill;
    logic [SW-1:0]  r_ds;
    logic [31:0]    r_pos;
    logic [28:0]    r_skip;
    logic           r_lock;
    logic [1:0]     r_lly;
    logic [15:0]    r_lhz;
    logic [CB-1:0]  r_cnt;
    logic [SMW-1:0] r_sum;
    logic [8:0]     r_hbr;
    logic [1:0]     r_hly;
    logic [15:0]    r_hhz;
    logic           r_hpad;
    logic [8:0]     r_avg;
    logic [DW-1:0]  r_mul;

    logic           r_o_valid;

    // ---- header decode at the window head
    logic [7:0]  h0, h1, h2;
    logic [1:0]  vi, ly;
    logic        ver_ok;
    logic [8:0]  br;
    logic [15:0] hzv;
    logic [17:0] kmul;
    logic [26:0] num;
    logic [FW:0] df_sum;

    assign h0 = r_win[0];
    assign h1 = r_win[1];
    assign h2 = r_win[2];
    assign ly = 2'd3 - h1[2:1];

    always_comb begin
        ver_ok = 1'b1;
        unique case (h1[4:3])
            mafs_pkg::VER_MPEG1:  vi = 2'd0;
            mafs_pkg::VER_MPEG2:  vi = 2'd1;
            mafs_pkg::VER_MPEG25: vi = 2'd2;
            default: begin
                vi     = 2'd0;
                ver_ok = 1'b0;
            end
        endcase
    end

    assign br  = mafs_pkg::kbps(4'(vi) * 4'd3 + 4'(ly), h2[7:4]);
    assign hzv = mafs_pkg::hz(vi, h2[3:2]);

    always_comb begin
        if (ly == mafs_pkg::LAYER_1)
            kmul = mafs_pkg::K_LAYER1;
        else if (ly == mafs_pkg::LAYER_3 && vi != 2'd0)
            kmul = mafs_pkg::K_HALF;
        else
            kmul = mafs_pkg::K_FULL;
    end
    assign num = 27'(kmul) * 27'(br);

    assign df_sum = (FW+1)'(r_ds) + (FW+1)'(r_fill);

    assign o_sts.scan_en    = (r_ds == '0) ? (r_fill == FW'(W)) : (df_sum >= (FW+1)'(W));
    assign o_sts.drain_last = r_ds == SW'(W - 1);
    assign o_sts.skip_nz    = r_skip != '0;
    assign o_sts.hdr_ok     = h0 == mafs_pkg::SYNC_BYTE
                            && (h1 & mafs_pkg::SYNC_MASK) == mafs_pkg::SYNC_MASK
                            && ver_ok && ly != mafs_pkg::LAYER_NONE
                            && !(r_lock && ly != r_lly)
                            && !(r_lhz != 16'd0 && hzv != r_lhz)
                            && br != 9'd0 && hzv != 16'd0;
    assign o_sts.id3_hit    = h1 == mafs_pkg::CHR_D
                            && ((h0 == mafs_pkg::CHR_I && h2 == mafs_pkg::CHR_3)
                             || (h0 == mafs_pkg::CHR_3 && h2 == mafs_pkg::CHR_I));
    assign o_sts.count_nz   = r_cnt != '0;
    assign o_sts.out_free   = !r_o_valid || !i_stall;

    // ---- shared divider
    logic [DW-1:0] div_a;
    logic [VW-1:0] div_b;
    logic [DW-1:0] quo;
    logic          div_busy;

    always_comb begin
        unique case (i_cmd.div_sel)
            mafs_pkg::DIV_HDR: begin
                div_a = DW'(num);
                div_b = VW'(hzv);
            end
            mafs_pkg::DIV_AVG: begin
                div_a = DW'({r_sum, 1'b0}) + DW'(r_cnt);
                div_b = r_cnt;
            end
            default: begin
                div_a = r_mul;
                div_b = VW'(r_lhz);
            end
        endcase
    end

    mafs_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );
    assign o_sts.div_busy = div_busy;

    // ---- frame commit values
    logic [13:0]   q_pad;
    logic [14:0]   fsize;
    logic [CB-1:0] cnt_after;
    logic          cnt_room;
    logic [31:0]   cnt32;
    logic [23:0]   tot_sat;
    logic [10:0]   spf;

    assign q_pad     = 14'(quo[12:0]) + 14'(r_hpad);
    assign fsize     = (r_hly == mafs_pkg::LAYER_1) ? {q_pad[12:0], 2'b00} : 15'(q_pad);
    assign cnt_room  = r_cnt != CNT_MAX;
    assign cnt_after = cnt_room ? r_cnt + 1'b1 : r_cnt;
    assign cnt32     = i_cmd.out_frame ? 32'(cnt_after) : 32'(r_cnt);
    assign tot_sat   = (cnt32 > 32'(mafs_pkg::SAT24)) ? mafs_pkg::SAT24 : cnt32[23:0];

    always_comb begin
        if (r_lly == mafs_pkg::LAYER_1)
            spf = mafs_pkg::SPF_L1;
        else if (r_lly == mafs_pkg::LAYER_3 && r_lhz < mafs_pkg::HZ_MPEG1_MIN)
            spf = mafs_pkg::SPF_HALF;
        else
            spf = mafs_pkg::SPF_FULL;
    end

    // ---- window and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < W; k++) r_win[k] <= 8'd0;
        end else if (i_cmd.shift_in || i_cmd.shift_drain) begin
            for (int k = 0; k < W - 1; k++) r_win[k] <= r_win[k+1];
            r_win[W-1] <= i_cmd.shift_in ? i_data_byte : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill <= '0;
            r_ds   <= '0;
            r_pos  <= POS_INIT;
            r_skip <= '0;
            r_lock <= 1'b0;
            r_lly  <= 2'd0;
            r_lhz  <= 16'd0;
            r_cnt  <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.shift_in) begin
                r_ds <= '0;
                if (r_fill != FW'(W)) r_fill <= r_fill + 1'b1;
            end else if (i_cmd.shift_drain) begin
                r_ds <= r_ds + 1'b1;
            end
            if (i_cmd.shift_in || i_cmd.shift_drain) r_pos <= r_pos + 32'd1;
            if (i_cmd.skip_dec) begin
                r_skip <= r_skip - 29'd1;
            end else if (i_cmd.id3_load) begin
                r_skip <= 29'({r_win[6][6:0], r_win[7][6:0], r_win[8][6:0],
                               r_win[9][6:0]}) + 29'd9;
            end else if (i_cmd.frame_commit) begin
                r_skip <= 29'(fsize) - 29'd1;
            end
            if (i_cmd.frame_commit) begin
                r_lock <= 1'b1;
                r_lly  <= r_hly;
                r_lhz  <= r_hhz;
                r_cnt  <= cnt_after;
                if (cnt_room) r_sum <= r_sum + SMW'(r_hbr);
            end
        end
    end

    // hold the decoded header while the size division runs
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && i_cmd.div_sel == mafs_pkg::DIV_HDR) begin
            r_hbr  <= br;
            r_hly  <= ly;
            r_hhz  <= hzv;
            r_hpad <= h2[1];
        end
        if (i_cmd.avg_store) r_avg <= quo[9:1];
        if (i_cmd.mul_store) r_mul <= DW'(spf) * DW'(r_cnt);
    end

    // ---- result register
    logic rate_nz;
    assign rate_nz = r_lhz != 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_frame || i_cmd.out_sum) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_frame) begin
            o_result_kind      <= 1'b0;
            o_frame_offset     <= r_pos;
            o_frame_length     <= (fsize > 15'(mafs_pkg::LEN_MAX)) ? mafs_pkg::LEN_MAX
                                                                  : fsize[10:0];
            o_frame_bitrate    <= r_hbr;
            o_total_frames     <= tot_sat;
            o_average_bitrate  <= 9'd0;
            o_duration_seconds <= 24'd0;
            o_sample_rate      <= r_hhz;
            o_layer_code       <= r_hly;
            o_is_last          <= 1'b0;
        end else if (i_cmd.out_sum) begin
            o_result_kind      <= 1'b1;
            o_frame_offset     <= 32'd0;
            o_frame_length     <= 11'd0;
            o_frame_bitrate    <= 9'd0;
            o_total_frames     <= tot_sat;
            o_average_bitrate  <= o_sts.count_nz ? r_avg : 9'd0;
            if (o_sts.count_nz && rate_nz)
                o_duration_seconds <= (quo > DW'(mafs_pkg::SAT24)) ? mafs_pkg::SAT24
                                                                   : quo[23:0];
            else
                o_duration_seconds <= 24'd0;
            o_sample_rate      <= r_lhz;
            o_layer_code       <= r_lock ? r_lly : mafs_pkg::LAYER_NONE;
            o_is_last          <= 1'b1;
        end
    end

    assign o_valid = r_o_valid;
endmodule
`default_nettype wire

// ----- rtl/core/mafs_ctrl.sv -----
// Controller state machine: sequences byte intake, scan, drain and summary.
// Depends on mafs_pkg; drives mafs_dp through t_cmd and reads t_sts.
`default_nettype none
module mafs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_end_of_file,
    output logic                o_stall,
    input  wire mafs_pkg::t_sts i_sts,
    output mafs_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_HDIV  = 3'd2;
    localparam logic [2:0] S_FRAME = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_AVG   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_DUR   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_eof, r_emitted, r_sum_pend;
    logic       n_eof, n_emitted, n_sum_pend;
    logic       adv;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_eof      = r_eof;
        n_emitted  = r_emitted;
        n_sum_pend = r_sum_pend;
        adv        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.shift_in = 1'b1;
                    n_eof          = i_end_of_file;
                    n_emitted      = 1'b0;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (!i_sts.scan_en) begin
                    adv = 1'b1;
                end else if (i_sts.skip_nz) begin
                    o_cmd.skip_dec = 1'b1;
                    adv            = 1'b1;
                end else if (i_sts.hdr_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = mafs_pkg::DIV_HDR;
                    n_state         = S_HDIV;
                end else if (i_sts.id3_hit) begin
                    o_cmd.id3_load = 1'b1;
                    adv            = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            S_HDIV: begin
                if (!i_sts.div_busy) n_state = S_FRAME;
            end
            S_FRAME: begin
                // only the first frame of a step is reported, and only it waits for the result slot
                if (r_emitted || i_sts.out_free) begin
                    o_cmd.frame_commit = 1'b1;
                    o_cmd.out_frame    = !r_emitted;
                    n_emitted          = 1'b1;
                    adv                = 1'b1;
                end
            end
            S_SUM: begin
                if (r_sum_pend) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_sum = 1'b1;
                        o_cmd.clear   = 1'b1;
                        n_sum_pend    = 1'b0;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.count_nz) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = mafs_pkg::DIV_AVG;
                    n_state         = S_AVG;
                end else begin
                    n_sum_pend = 1'b1;
                end
            end
            S_AVG: begin
                if (!i_sts.div_busy) begin
                    o_cmd.avg_store = 1'b1;
                    o_cmd.mul_store = 1'b1;
                    n_state         = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = mafs_pkg::DIV_DUR;
                n_state         = S_DUR;
            end
            S_DUR: begin
                o_cmd.div_sel = mafs_pkg::DIV_DUR;
                if (!i_sts.div_busy) begin
                    n_sum_pend = 1'b1;
                    n_state    = S_SUM;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // advance: next drain position, summary, or back to intake
        if (adv) begin
            if (r_eof) begin
                if (i_sts.drain_last) begin
                    n_state = S_SUM;
                end else begin
                    o_cmd.shift_drain = 1'b1;
                    n_state           = S_EVAL;
                end
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_eof      <= 1'b0;
            r_emitted  <= 1'b0;
            r_sum_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_eof      <= n_eof;
            r_emitted  <= n_emitted;
            r_sum_pend <= n_sum_pend;
        end
    end

    assign o_stall = r_state != S_IDLE;
endmodule
`default_nettype wire

// ----- rtl/core/mpeg_audio_frame_scanner.sv -----
// Top level of the MPEG audio frame scanner: controller plus datapath.
// Depends on mafs_pkg, mafs_ctrl, mafs_dp (which holds mafs_div).
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_stall  | i_data_byte, i_end_of_file
//  result  | out       | o_valid / i_stall  | o_result_kind ... o_is_last (10 fields)
//
// Each byte is taken into the window, and then the scan position at the window
// head is evaluated. A frame header adds a division in the bit-serial divider,
// which computes the frame size. The last byte adds up to WINDOW_BYTES-1 more
// evaluations (each one a header division at most) and a summary that runs two
// divisions, for the average bitrate and the duration.
// Reset is synchronous and active low; the block also returns to reset state
// after each summary. The result register frees the input side: bytes keep
// flowing while a transaction waits; only emitting a new result stalls.
`default_nettype none
module mpeg_audio_frame_scanner #(
    parameter int WINDOW_BYTES = 10,
    parameter int COUNT_BITS   = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_file,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_result_kind,
    output logic [31:0]      o_frame_offset,
    output logic [10:0]      o_frame_length,
    output logic [8:0]       o_frame_bitrate,
    output logic [23:0]      o_total_frames,
    output logic [8:0]       o_average_bitrate,
    output logic [23:0]      o_duration_seconds,
    output logic [15:0]      o_sample_rate,
    output logic [1:0]       o_layer_code,
    output logic             o_is_last
);
    mafs_pkg::t_cmd cmd;
    mafs_pkg::t_sts sts;

    // sequence intake, scanning, drain and summary
    mafs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_end_of_file (i_end_of_file),
        .o_stall       (o_stall),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    // window, decode, divider and result register
    mafs_dp #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_data_byte        (i_data_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_kind      (o_result_kind),
        .o_frame_offset     (o_frame_offset),
        .o_frame_length     (o_frame_length),
        .o_frame_bitrate    (o_frame_bitrate),
        .o_total_frames     (o_total_frames),
        .o_average_bitrate  (o_average_bitrate),
        .o_duration_seconds (o_duration_seconds),
        .o_sample_rate      (o_sample_rate),
        .o_layer_code       (o_layer_code),
        .o_is_last          (o_is_last)
    );
endmodule
`default_nettype wire
